@@ hdl/mfb_pkg.sv @@
// shared constants, types and helpers for the monochrome frame buffer rectangle fill
package mfb_pkg;

  // screen geometry
  localparam int SCREEN_WIDTH  = 144;
  localparam int SCREEN_HEIGHT = 168;
  localparam int ROW_STRIDE    = 20;
  localparam int FRAME_BYTES   = SCREEN_HEIGHT * ROW_STRIDE;

  // derived widths
  localparam int MEM_AW = $clog2(FRAME_BYTES + 1);
  localparam int X_W    = $clog2(SCREEN_WIDTH + 1);
  localparam int Y_W    = $clog2(SCREEN_HEIGHT + 1);
  localparam int COL_W  = $clog2((SCREEN_WIDTH >> 3) + ROW_STRIDE + 1);

  // last byte column that a fill may touch
  localparam int LAST_COL = ROW_STRIDE - 2;

  // configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_GREY_EVEN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GREY_ODD  = CFG_IDX_W'(1);

  // register reset values
  localparam logic [7:0] GREY_EVEN_RST = 8'd170;
  localparam logic [7:0] GREY_ODD_RST  = 8'd85;

  // colour codes and fill bytes
  localparam logic [7:0] COLOR_MODE_MASK = 8'hC0;
  localparam logic [7:0] COLOR_BLACK     = 8'hC0;
  localparam logic [7:0] COLOR_WHITE     = 8'hFF;
  localparam logic [7:0] PAT_BLACK       = 8'h00;
  localparam logic [7:0] PAT_WHITE       = 8'hFF;
  localparam logic [7:0] MASK_FULL       = 8'hFF;

  // opcodes
  localparam logic OP_FILL = 1'b0;
  localparam logic OP_READ = 1'b1;

  // one input beat
  typedef struct packed {
    logic               opcode;
    logic signed [15:0] rect_left;
    logic signed [15:0] rect_top;
    logic signed [15:0] rect_width;
    logic signed [15:0] rect_height;
    logic [7:0]         fill_color;
    logic [11:0]        read_address;
  } in_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic clr_step;
    logic capture;
    logic clip;
    logic setup;
    logic fill_step;
    logic out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic is_read;
    logic empty;
    logic fill_last;
    logic out_busy;
  } status_t;

  // clamp a 17-bit signed edge into 0..hi
  function automatic logic [15:0] clamp_edge(input logic signed [16:0] v, input int hi);
    logic [15:0] res;
    if (v < 0) begin
      res = 16'd0;
    end else if (v > hi) begin
      res = 16'(hi);
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

endpackage

@@ hdl/mfb_if.sv @@
// valid/ready channel interfaces for input, result and configuration beats
interface mfb_in_if;
  import mfb_pkg::*;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [15:0] rect_left;
  logic signed [15:0] rect_top;
  logic signed [15:0] rect_width;
  logic signed [15:0] rect_height;
  logic [7:0]         fill_color;
  logic [11:0]        read_address;

  modport source (output valid, opcode, rect_left, rect_top, rect_width, rect_height,
                  fill_color, read_address, input ready);
  modport sink   (input valid, opcode, rect_left, rect_top, rect_width, rect_height,
                  fill_color, read_address, output ready);
endinterface

interface mfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

interface mfb_cfg_if;
  import mfb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/mfb_ctrl.sv @@
// controller state machine: sequences clear pass, fill walk and byte read
module mfb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output mfb_pkg::cmd_t    cmd,
  input  mfb_pkg::status_t status
);
  import mfb_pkg::*;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_CLIP  = 8'b0000_0100,
    ST_SETUP = 8'b0000_1000,
    ST_FILL  = 8'b0001_0000,
    ST_FLUSH = 8'b0010_0000,
    ST_RD    = 8'b0100_0000,
    ST_RDOUT = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_CLIP;
        end
      end
      ST_CLIP: begin
        if (status.is_read) begin
          state_nxt = ST_RD;
        end else begin
          cmd.clip  = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (status.empty) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.setup = 1'b1;
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (status.fill_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // last merge lands in the store this cycle
        state_nxt = ST_IDLE;
      end
      ST_RD: begin
        state_nxt = ST_RDOUT;
      end
      ST_RDOUT: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

@@ hdl/mfb_datapath.sv @@
// datapath: frame store, clipping, byte walk with read-modify-write and result register
module mfb_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mfb_pkg::in_item_t              in_item,
  input  logic                           cfg_we,
  input  logic [mfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [7:0]                     out_data,
  input  mfb_pkg::cmd_t                  cmd,
  output mfb_pkg::status_t               status
);
  import mfb_pkg::*;

  // frame store
  logic [7:0] mem [FRAME_BYTES];
  logic [7:0] mem_q_r;

  // registers
  logic [7:0]        grey_even_r, grey_odd_r;
  in_item_t          item_r;
  logic [X_W-1:0]    x1c_r, x2c_r;
  logic [Y_W-1:0]    y1c_r, y2c_r;
  logic [COL_W-1:0]  lb_r, rb_r, last_r, col_r;
  logic [7:0]        lmask_r, rmask_r;
  logic [Y_W-1:0]    row_r, row_last_r;
  logic [MEM_AW-1:0] base_r;
  logic [MEM_AW-1:0] clr_cnt_r;
  logic              wr_valid_r;
  logic [MEM_AW-1:0] wr_addr_r;
  logic [7:0]        wr_mask_r, wr_pat_r;
  logic              out_valid_r;
  logic [7:0]        out_data_r;

  // combinational
  logic signed [16:0] x1s, y1s, x2s, y2s;
  logic [COL_W-1:0]   lb_c, rb_c, rb_eff_c, last_c;
  logic [7:0]         lmask_c, rmask_c;
  logic               no_paint;
  logic [MEM_AW-1:0]  fill_addr, rd_mem_addr, raddr;
  logic [7:0]         mask_c, pat_c;
  logic               col_end;
  logic               rd_in_range;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grey_even_r <= GREY_EVEN_RST;
      grey_odd_r  <= GREY_ODD_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_GREY_EVEN) begin
        grey_even_r <= cfg_data;
      end else if (cfg_index == CFG_GREY_ODD) begin
        grey_odd_r <= cfg_data;
      end
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
  end

  // edge sums at full precision
  assign x1s = {item_r.rect_left[15], item_r.rect_left};
  assign y1s = {item_r.rect_top[15], item_r.rect_top};
  assign x2s = x1s + {item_r.rect_width[15], item_r.rect_width};
  assign y2s = y1s + {item_r.rect_height[15], item_r.rect_height};

  // clipped corners
  always_ff @(posedge clk) begin
    if (cmd.clip) begin
      x1c_r <= X_W'(clamp_edge(x1s, SCREEN_WIDTH));
      x2c_r <= X_W'(clamp_edge(x2s, SCREEN_WIDTH));
      y1c_r <= Y_W'(clamp_edge(y1s, SCREEN_HEIGHT));
      y2c_r <= Y_W'(clamp_edge(y2s, SCREEN_HEIGHT));
    end
  end

  // byte range and edge masks from the clipped corners
  assign lb_c     = COL_W'(x1c_r >> 3);
  assign rb_c     = COL_W'(x2c_r >> 3);
  assign lmask_c  = 8'hFF << x1c_r[2:0];
  assign rmask_c  = ~(8'hFF << x2c_r[2:0]);
  assign rb_eff_c = (rmask_c != 8'h00) ? rb_c : rb_c - COL_W'(1);
  assign last_c   = (int'(rb_eff_c) > LAST_COL) ? COL_W'(LAST_COL) : rb_eff_c;
  assign no_paint = ((item_r.fill_color & COLOR_MODE_MASK) == 8'h00);

  assign status.empty = no_paint || (x2c_r <= x1c_r) || (y2c_r <= y1c_r) ||
                        (int'(lb_c) >= ROW_STRIDE - 1) || (lb_c > rb_eff_c);

  // per-byte mask and fill pattern
  assign mask_c = ((col_r == lb_r) ? lmask_r : MASK_FULL) &
                  ((col_r == rb_r) ? rmask_r : MASK_FULL);

  always_comb begin
    if (item_r.fill_color == COLOR_BLACK) begin
      pat_c = PAT_BLACK;
    end else if (item_r.fill_color == COLOR_WHITE) begin
      pat_c = PAT_WHITE;
    end else if (row_r[0]) begin
      pat_c = grey_odd_r;
    end else begin
      pat_c = grey_even_r;
    end
  end

  assign fill_addr        = base_r + MEM_AW'(col_r);
  assign col_end          = (col_r == last_r);
  assign status.fill_last = col_end && (row_r == row_last_r);

  // walk setup and byte/row counters
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      lb_r       <= lb_c;
      rb_r       <= rb_c;
      last_r     <= last_c;
      lmask_r    <= lmask_c;
      rmask_r    <= rmask_c;
      col_r      <= lb_c;
      row_r      <= '0;
      row_last_r <= y2c_r - y1c_r - Y_W'(1);
      base_r     <= MEM_AW'(int'(y1c_r) * ROW_STRIDE);
    end else if (cmd.fill_step) begin
      if (col_end) begin
        col_r  <= lb_r;
        row_r  <= row_r + Y_W'(1);
        base_r <= base_r + MEM_AW'(ROW_STRIDE);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  // merge stage: follows the read in the next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_valid_r <= 1'b0;
    end else begin
      wr_valid_r <= cmd.fill_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_step) begin
      wr_addr_r <= fill_addr;
      wr_mask_r <= mask_c;
      wr_pat_r  <= pat_c;
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + MEM_AW'(1);
    end
  end

  assign status.clr_last = (int'(clr_cnt_r) == FRAME_BYTES - 1);

  // store read and write ports
  assign rd_mem_addr = MEM_AW'(item_r.read_address);
  assign raddr       = cmd.fill_step ? fill_addr : rd_mem_addr;
  assign rd_in_range = (int'(item_r.read_address) < FRAME_BYTES);

  always_ff @(posedge clk) begin
    mem_q_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_cnt_r] <= 8'h00;
    end else if (wr_valid_r) begin
      mem[wr_addr_r] <= (mem_q_r & ~wr_mask_r) | (wr_pat_r & wr_mask_r);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= rd_in_range ? mem_q_r : 8'h00;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;
  assign status.out_busy = out_valid_r && !out_ready;
  assign status.is_read  = (item_r.opcode == OP_READ);

endmodule

@@ hdl/mono_framebuffer_rect_fill.sv @@
// top level: 1 bpp frame store with clipped rectangle fill and byte read
// After reset the block sweeps the 3360-byte frame store to zero, one byte per cycle, and
// takes no command until the sweep is done; configuration writes are taken at any time. A
// read command passes decode and the registered store read, then loads its byte into the
// output register once it is free. A fill command is decoded, clipped and set up, then
// walks each clipped row byte by byte through a pipelined read-modify-write on the single
// store write port, and a flush state drains the last merge; a full-screen fill is 168
// rows of 18 bytes. A fill that clips to nothing, or has a clear colour, returns to idle
// from setup without writing the store. One command is in progress at a time; a read
// result waits in an output register without holding up the next command's acceptance.
module mono_framebuffer_rect_fill (
  input logic       clk,
  input logic       rst_n,
  mfb_in_if.sink    in_ch,
  mfb_out_if.source out_ch,
  mfb_cfg_if.sink   cfg_ch
);
  import mfb_pkg::*;

  cmd_t     cmd;
  status_t  status;
  in_item_t in_item;

  // pack the input beat
  assign in_item.opcode       = in_ch.opcode;
  assign in_item.rect_left    = in_ch.rect_left;
  assign in_item.rect_top     = in_ch.rect_top;
  assign in_item.rect_width   = in_ch.rect_width;
  assign in_item.rect_height  = in_ch.rect_height;
  assign in_item.fill_color   = in_ch.fill_color;
  assign in_item.read_address = in_ch.read_address;

  // configuration writes are always taken
  assign cfg_ch.ready = 1'b1;

  mfb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .status   (status)
  );

  mfb_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_data  (out_ch.read_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
